// ----- sv/pi16alu_pkg.sv -----
// Shared types and constants for the packed 16-bit x8 SIMD ALU.
// Used by pi16alu_lane, pi16alu_core and packed_int16x8_alu_top; no dependencies.
package pi16alu_pkg;

  localparam int LaneW = 16;
  localparam int Lanes = 8;
  localparam int HalfW = 64;
  localparam int IdxW  = 4;
  localparam int CntW  = 5;

  localparam logic [CntW-1:0]  ShiftCap = 5'd16;
  localparam logic [LaneW-1:0] SatMax   = 16'h7fff;
  localparam logic [LaneW-1:0] SatMin   = 16'h8000;
  localparam logic [LaneW-1:0] MaskOnes = 16'hffff;

  typedef enum logic [4:0] {
    ACT_SPLAT   = 5'd0,
    ACT_SPLAT0  = 5'd1,
    ACT_NEG     = 5'd2,
    ACT_NOT     = 5'd3,
    ACT_ADD     = 5'd4,
    ACT_SUB     = 5'd5,
    ACT_MUL     = 5'd6,
    ACT_AND     = 5'd7,
    ACT_OR      = 5'd8,
    ACT_XOR     = 5'd9,
    ACT_ADDSAT  = 5'd10,
    ACT_SUBSAT  = 5'd11,
    ACT_MIN     = 5'd12,
    ACT_MAX     = 5'd13,
    ACT_LT      = 5'd14,
    ACT_LE      = 5'd15,
    ACT_EQ      = 5'd16,
    ACT_NE      = 5'd17,
    ACT_GT      = 5'd18,
    ACT_GE      = 5'd19,
    ACT_EXTRACT = 5'd20,
    ACT_REPLACE = 5'd21,
    ACT_SHL     = 5'd22,
    ACT_SHRL    = 5'd23,
    ACT_SHRA    = 5'd24
  } action_t;

  // One accepted input item
  typedef struct packed {
    logic [4:0]        action;
    logic [HalfW-1:0]  a_low;
    logic [HalfW-1:0]  a_high;
    logic [HalfW-1:0]  b_low;
    logic [HalfW-1:0]  b_high;
    logic [IdxW-1:0]   lane_index;
    logic [LaneW-1:0]  scalar_value;
    logic [CntW-1:0]   shift_count;
  } item_t;

  // One result item
  typedef struct packed {
    logic [HalfW-1:0]  result_low;
    logic [HalfW-1:0]  result_high;
    logic [LaneW-1:0]  lane_value;
  } result_t;

endpackage

// ----- sv/packed_int16x8_alu_top.sv -----
// Packed 16-bit x8 SIMD ALU, top level with valid/ready channels.
// Path: the input register captures each accepted item, the combinational core works on it,
// and the result register captures the result before it is presented on the outputs.
// Throughput: one item per cycle; input stalls only while both registers hold items and
// out_ready is low. Reset (rst, synchronous, active high) clears both valid flags.
// Depends on pi16alu_pkg and pi16alu_core.
module packed_int16x8_alu_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [4:0]                           action,
  input  logic [pi16alu_pkg::HalfW-1:0]        a_low,
  input  logic [pi16alu_pkg::HalfW-1:0]        a_high,
  input  logic [pi16alu_pkg::HalfW-1:0]        b_low,
  input  logic [pi16alu_pkg::HalfW-1:0]        b_high,
  input  logic [pi16alu_pkg::IdxW-1:0]         lane_index,
  input  logic signed [pi16alu_pkg::LaneW-1:0] scalar_value,
  input  logic [pi16alu_pkg::CntW-1:0]         shift_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pi16alu_pkg::HalfW-1:0]        result_low,
  output logic [pi16alu_pkg::HalfW-1:0]        result_high,
  output logic signed [pi16alu_pkg::LaneW-1:0] lane_value
);

  pi16alu_pkg::item_t   item_q;
  logic                 item_valid;
  pi16alu_pkg::result_t res_next;
  pi16alu_pkg::result_t res_q;
  logic                 res_valid;
  logic                 res_load;

  // Advance into the result register when it is empty or being drained
  assign res_load = !res_valid || out_ready;
  assign in_ready = !item_valid || res_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_q <= '{action:       action,
                  a_low:        a_low,
                  a_high:       a_high,
                  b_low:        b_low,
                  b_high:       b_high,
                  lane_index:   lane_index,
                  scalar_value: scalar_value,
                  shift_count:  shift_count};
    end
  end

  pi16alu_core u_core (
    .item (item_q),
    .res  (res_next)
  );

  // Result register; hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= item_valid;
    end
    if (res_load && item_valid) begin
      res_q <= res_next;
    end
  end

  assign out_valid   = res_valid;
  assign result_low  = res_q.result_low;
  assign result_high = res_q.result_high;
  assign lane_value  = res_q.lane_value;

endmodule

// ----- sv/pi16alu_lane.sv -----
// One 16-bit lane of the SIMD ALU: arithmetic, logic, compare and shift.
// Depends on pi16alu_pkg.
module pi16alu_lane (
  input  pi16alu_pkg::action_t                act,
  input  logic [pi16alu_pkg::LaneW-1:0]       ua,
  input  logic [pi16alu_pkg::LaneW-1:0]       ub,
  input  logic [pi16alu_pkg::LaneW-1:0]       a0,
  input  logic [pi16alu_pkg::LaneW-1:0]       scal,
  input  logic [pi16alu_pkg::CntW-1:0]        cnt,
  input  logic                                hit,
  output logic [pi16alu_pkg::LaneW-1:0]       r
);

  logic signed [pi16alu_pkg::LaneW-1:0] sa;
  logic signed [pi16alu_pkg::LaneW-1:0] sb;
  logic signed [pi16alu_pkg::LaneW:0]   sum_s;
  logic signed [pi16alu_pkg::LaneW:0]   dif_s;
  logic [pi16alu_pkg::LaneW-1:0]        prod;
  logic [pi16alu_pkg::LaneW-1:0]        sum_sat;
  logic [pi16alu_pkg::LaneW-1:0]        dif_sat;
  logic                                 lt;
  logic                                 eq;

  assign sa = $signed(ua);
  assign sb = $signed(ub);

  // Widen by one bit so overflow shows in the top two bits
  assign sum_s = {sa[pi16alu_pkg::LaneW-1], sa} + {sb[pi16alu_pkg::LaneW-1], sb};
  assign dif_s = {sa[pi16alu_pkg::LaneW-1], sa} - {sb[pi16alu_pkg::LaneW-1], sb};
  assign prod  = ua * ub;

  // Clamp on overflow: positive overflow to max, negative to min
  always_comb begin
    if (sum_s[pi16alu_pkg::LaneW] == sum_s[pi16alu_pkg::LaneW-1]) begin
      sum_sat = sum_s[pi16alu_pkg::LaneW-1:0];
    end else if (sum_s[pi16alu_pkg::LaneW]) begin
      sum_sat = pi16alu_pkg::SatMin;
    end else begin
      sum_sat = pi16alu_pkg::SatMax;
    end
    if (dif_s[pi16alu_pkg::LaneW] == dif_s[pi16alu_pkg::LaneW-1]) begin
      dif_sat = dif_s[pi16alu_pkg::LaneW-1:0];
    end else if (dif_s[pi16alu_pkg::LaneW]) begin
      dif_sat = pi16alu_pkg::SatMin;
    end else begin
      dif_sat = pi16alu_pkg::SatMax;
    end
  end

  assign lt = (sa < sb);
  assign eq = (ua == ub);

  // Select the lane result by operation
  always_comb begin
    case (act)
      pi16alu_pkg::ACT_SPLAT:   r = scal;
      pi16alu_pkg::ACT_SPLAT0:  r = a0;
      pi16alu_pkg::ACT_NEG:     r = 16'd0 - ua;
      pi16alu_pkg::ACT_NOT:     r = ~ua;
      pi16alu_pkg::ACT_ADD:     r = ua + ub;
      pi16alu_pkg::ACT_SUB:     r = ua - ub;
      pi16alu_pkg::ACT_MUL:     r = prod;
      pi16alu_pkg::ACT_AND:     r = ua & ub;
      pi16alu_pkg::ACT_OR:      r = ua | ub;
      pi16alu_pkg::ACT_XOR:     r = ua ^ ub;
      pi16alu_pkg::ACT_ADDSAT:  r = sum_sat;
      pi16alu_pkg::ACT_SUBSAT:  r = dif_sat;
      pi16alu_pkg::ACT_MIN:     r = lt ? ua : ub;
      pi16alu_pkg::ACT_MAX:     r = (!lt && !eq) ? ua : ub;
      pi16alu_pkg::ACT_LT:      r = lt ? pi16alu_pkg::MaskOnes : '0;
      pi16alu_pkg::ACT_LE:      r = (lt || eq) ? pi16alu_pkg::MaskOnes : '0;
      pi16alu_pkg::ACT_EQ:      r = eq ? pi16alu_pkg::MaskOnes : '0;
      pi16alu_pkg::ACT_NE:      r = !eq ? pi16alu_pkg::MaskOnes : '0;
      pi16alu_pkg::ACT_GT:      r = (!lt && !eq) ? pi16alu_pkg::MaskOnes : '0;
      pi16alu_pkg::ACT_GE:      r = !lt ? pi16alu_pkg::MaskOnes : '0;
      pi16alu_pkg::ACT_EXTRACT: r = '0;
      pi16alu_pkg::ACT_REPLACE: r = hit ? scal : ua;
      // Count is capped at 16; bit 4 set means everything shifted out
      pi16alu_pkg::ACT_SHL:     r = cnt[pi16alu_pkg::CntW-1] ? '0 : (ua << cnt[3:0]);
      pi16alu_pkg::ACT_SHRL:    r = ua >> cnt;
      pi16alu_pkg::ACT_SHRA:    r = 16'(sa >>> cnt);
      default:                  r = '0;
    endcase
  end

endmodule

// ----- sv/pi16alu_core.sv -----
// Combinational datapath: eight lane units plus the lane extract.
// Depends on pi16alu_pkg and pi16alu_lane.
module pi16alu_core (
  input  pi16alu_pkg::item_t   item,
  output pi16alu_pkg::result_t res
);

  logic [pi16alu_pkg::Lanes*pi16alu_pkg::LaneW-1:0] a_vec;
  logic [pi16alu_pkg::Lanes*pi16alu_pkg::LaneW-1:0] b_vec;
  logic [pi16alu_pkg::Lanes*pi16alu_pkg::LaneW-1:0] r_vec;
  logic [pi16alu_pkg::CntW-1:0]                     cnt;
  pi16alu_pkg::action_t                             act;
  logic                                             idx_ok;
  logic [pi16alu_pkg::LaneW-1:0]                    lane_val;

  assign a_vec  = {item.a_high, item.a_low};
  assign b_vec  = {item.b_high, item.b_low};
  assign act    = pi16alu_pkg::action_t'(item.action);
  assign idx_ok = (item.lane_index < 4'(pi16alu_pkg::Lanes));

  // Cap the shift count
  assign cnt = (item.shift_count > pi16alu_pkg::ShiftCap) ? pi16alu_pkg::ShiftCap
                                                         : item.shift_count;

  for (genvar i = 0; i < pi16alu_pkg::Lanes; i++) begin : g_lane
    pi16alu_lane u_lane (
      .act  (act),
      .ua   (a_vec[i*pi16alu_pkg::LaneW +: pi16alu_pkg::LaneW]),
      .ub   (b_vec[i*pi16alu_pkg::LaneW +: pi16alu_pkg::LaneW]),
      .a0   (a_vec[pi16alu_pkg::LaneW-1:0]),
      .scal (item.scalar_value),
      .cnt  (cnt),
      .hit  (item.lane_index == 4'(i)),
      .r    (r_vec[i*pi16alu_pkg::LaneW +: pi16alu_pkg::LaneW])
    );
  end

  assign res.result_low  = r_vec[pi16alu_pkg::HalfW-1:0];
  assign res.result_high = r_vec[2*pi16alu_pkg::HalfW-1:pi16alu_pkg::HalfW];
  assign res.lane_value  = lane_val;

  // Extract lane of a; zero when out of range or not extract
  always_comb begin
    lane_val = '0;
    if (act == pi16alu_pkg::ACT_EXTRACT && idx_ok) begin
      lane_val = a_vec[item.lane_index[2:0]*pi16alu_pkg::LaneW +: pi16alu_pkg::LaneW];
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for packed_int16x8_alu_top: a lane-by-lane predictor of the
// eight-lane 16-bit ALU fed by directed corner items and random traffic with random stalls.
// Depends on pi16alu_pkg and the RTL of packed_int16x8_alu_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 1150;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;
  localparam int PrintCap    = 20;

  // Action codes the block leaves unused
  localparam logic [4:0] ActUnusedLow = 5'd25;
  localparam logic [4:0] ActUnusedTop = 5'd31;

  // Lane 7 down to lane 0: limits, sign boundaries, equal lanes and overflow pairs
  localparam logic [127:0] CornerA = {16'h1234, 16'h7ffe, 16'h8001, 16'h0001,
                                      16'h0000, 16'hffff, 16'h8000, 16'h7fff};
  localparam logic [127:0] CornerB = {16'hedcc, 16'h7ffe, 16'h8000, 16'hffff,
                                      16'h0001, 16'hffff, 16'h7fff, 16'h8000};

  // Expected-result store with the lane predictor
  class alu_scoreboard;
    pi16alu_pkg::result_t expected_q[$];
    int                   mismatches;
    int                   checked;
    int                   noted;

    function pi16alu_pkg::result_t simd_eval(pi16alu_pkg::item_t it);
      logic [127:0]         va, vb, vr;
      logic [15:0]          ua, ub, r, scal;
      int                   sa, sb, s, cnt;
      pi16alu_pkg::result_t res;
      va   = {it.a_high, it.a_low};
      vb   = {it.b_high, it.b_low};
      vr   = '0;
      scal = it.scalar_value;
      cnt  = (it.shift_count > pi16alu_pkg::ShiftCap) ? int'(pi16alu_pkg::ShiftCap)
                                                      : int'(it.shift_count);
      for (int i = 0; i < pi16alu_pkg::Lanes; i++) begin
        ua = va[pi16alu_pkg::LaneW*i +: pi16alu_pkg::LaneW];
        ub = vb[pi16alu_pkg::LaneW*i +: pi16alu_pkg::LaneW];
        sa = int'($signed(ua));
        sb = int'($signed(ub));
        case (it.action)
          pi16alu_pkg::ACT_SPLAT:   r = scal;
          pi16alu_pkg::ACT_SPLAT0:  r = va[pi16alu_pkg::LaneW-1:0];
          pi16alu_pkg::ACT_NEG:     r = -ua;
          pi16alu_pkg::ACT_NOT:     r = ~ua;
          pi16alu_pkg::ACT_ADD:     r = ua + ub;
          pi16alu_pkg::ACT_SUB:     r = ua - ub;
          pi16alu_pkg::ACT_MUL:     r = ua * ub;
          pi16alu_pkg::ACT_AND:     r = ua & ub;
          pi16alu_pkg::ACT_OR:      r = ua | ub;
          pi16alu_pkg::ACT_XOR:     r = ua ^ ub;
          pi16alu_pkg::ACT_ADDSAT, pi16alu_pkg::ACT_SUBSAT: begin
            s = (it.action == pi16alu_pkg::ACT_ADDSAT) ? sa + sb : sa - sb;
            if (s > int'($signed(pi16alu_pkg::SatMax))) r = pi16alu_pkg::SatMax;
            else if (s < int'($signed(pi16alu_pkg::SatMin))) r = pi16alu_pkg::SatMin;
            else r = s[15:0];
          end
          pi16alu_pkg::ACT_MIN:     r = (sa < sb) ? ua : ub;
          pi16alu_pkg::ACT_MAX:     r = (sa > sb) ? ua : ub;
          pi16alu_pkg::ACT_LT:      r = (sa < sb) ? pi16alu_pkg::MaskOnes : '0;
          pi16alu_pkg::ACT_LE:      r = (sa <= sb) ? pi16alu_pkg::MaskOnes : '0;
          pi16alu_pkg::ACT_EQ:      r = (sa == sb) ? pi16alu_pkg::MaskOnes : '0;
          pi16alu_pkg::ACT_NE:      r = (sa != sb) ? pi16alu_pkg::MaskOnes : '0;
          pi16alu_pkg::ACT_GT:      r = (sa > sb) ? pi16alu_pkg::MaskOnes : '0;
          pi16alu_pkg::ACT_GE:      r = (sa >= sb) ? pi16alu_pkg::MaskOnes : '0;
          pi16alu_pkg::ACT_REPLACE: r = (it.lane_index == i) ? scal : ua;
          pi16alu_pkg::ACT_SHL:     r = (cnt >= int'(pi16alu_pkg::ShiftCap)) ? '0 : ua << cnt;
          pi16alu_pkg::ACT_SHRL:    r = ua >> cnt;
          pi16alu_pkg::ACT_SHRA:    r = ua[15] ? ~((~ua) >> cnt) : ua >> cnt;
          default:                  r = '0;
        endcase
        vr[pi16alu_pkg::LaneW*i +: pi16alu_pkg::LaneW] = r;
      end
      res.result_low  = vr[63:0];
      res.result_high = vr[127:64];
      res.lane_value  = '0;
      if (it.action == pi16alu_pkg::ACT_EXTRACT && it.lane_index < pi16alu_pkg::Lanes)
        res.lane_value = va[pi16alu_pkg::LaneW*it.lane_index +: pi16alu_pkg::LaneW];
      return res;
    endfunction

    function void note_item(pi16alu_pkg::item_t it);
      expected_q.push_back(simd_eval(it));
      noted++;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PrintCap)
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(pi16alu_pkg::result_t got);
      pi16alu_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report("result arrived with no item pending");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.result_low !== want.result_low)
        report($sformatf("result_low got %h want %h", got.result_low, want.result_low));
      if (got.result_high !== want.result_high)
        report($sformatf("result_high got %h want %h", got.result_high, want.result_high));
      if (got.lane_value !== want.lane_value)
        report($sformatf("lane_value got %h want %h", got.lane_value, want.lane_value));
    endtask
  endclass

  logic                                 clk;
  logic                                 rst          = 1'b1;
  logic                                 in_valid     = 1'b0;
  logic                                 in_ready;
  logic [4:0]                           action       = '0;
  logic [pi16alu_pkg::HalfW-1:0]        a_low        = '0;
  logic [pi16alu_pkg::HalfW-1:0]        a_high       = '0;
  logic [pi16alu_pkg::HalfW-1:0]        b_low        = '0;
  logic [pi16alu_pkg::HalfW-1:0]        b_high       = '0;
  logic [pi16alu_pkg::IdxW-1:0]         lane_index   = '0;
  logic signed [pi16alu_pkg::LaneW-1:0] scalar_value = '0;
  logic [pi16alu_pkg::CntW-1:0]         shift_count  = '0;
  logic                                 out_valid;
  logic                                 out_ready    = 1'b0;
  logic [pi16alu_pkg::HalfW-1:0]        result_low;
  logic [pi16alu_pkg::HalfW-1:0]        result_high;
  logic signed [pi16alu_pkg::LaneW-1:0] lane_value;

  alu_scoreboard sb = new;
  bit            calm;
  int            stall_left;
  int            cycle_count;

  packed_int16x8_alu_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .a_low        (a_low),
    .a_high       (a_high),
    .b_low        (b_low),
    .b_high       (b_high),
    .lane_index   (lane_index),
    .scalar_value (scalar_value),
    .shift_count  (shift_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_low   (result_low),
    .result_high  (result_high),
    .lane_value   (lane_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long; none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // One lane, biased toward sign and saturation boundaries
  function automatic logic [15:0] rand_lane();
    if ($urandom_range(99) >= 30) return 16'($urandom);
    case ($urandom_range(5))
      0:       return pi16alu_pkg::SatMax;
      1:       return pi16alu_pkg::SatMin;
      2:       return pi16alu_pkg::MaskOnes;
      3:       return 16'h0001;
      4:       return 16'h8001;
      default: return '0;
    endcase
  endfunction

  function automatic pi16alu_pkg::item_t random_item();
    pi16alu_pkg::item_t it;
    logic [127:0]       va, vb;
    for (int i = 0; i < pi16alu_pkg::Lanes; i++) begin
      va[pi16alu_pkg::LaneW*i +: pi16alu_pkg::LaneW] = rand_lane();
      vb[pi16alu_pkg::LaneW*i +: pi16alu_pkg::LaneW] =
        ($urandom_range(3) == 0) ? va[pi16alu_pkg::LaneW*i +: pi16alu_pkg::LaneW] : rand_lane();
    end
    if ($urandom_range(99) < 4)
      it.action = 5'($urandom_range(int'(ActUnusedTop), int'(ActUnusedLow)));
    else
      it.action = 5'($urandom_range(int'(pi16alu_pkg::ACT_SHRA)));
    it.a_low        = va[63:0];
    it.a_high       = va[127:64];
    it.b_low        = vb[63:0];
    it.b_high       = vb[127:64];
    it.lane_index   = 4'($urandom);
    it.scalar_value = ($urandom_range(3) == 0) ? rand_lane() : 16'($urandom);
    if ($urandom_range(99) < 40)
      it.shift_count = 5'($urandom_range(int'(pi16alu_pkg::ShiftCap) + 2,
                                         int'(pi16alu_pkg::ShiftCap) - 2));
    else
      it.shift_count = 5'($urandom);
    return it;
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(pi16alu_pkg::item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    action       <= it.action;
    a_low        <= it.a_low;
    a_high       <= it.a_high;
    b_low        <= it.b_low;
    b_high       <= it.b_high;
    lane_index   <= it.lane_index;
    scalar_value <= it.scalar_value;
    shift_count  <= it.shift_count;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_corner(logic [4:0] act, logic [3:0] idx, logic [15:0] scal,
                             logic [4:0] cnt);
    pi16alu_pkg::item_t it;
    it.action       = act;
    it.a_low        = CornerA[63:0];
    it.a_high       = CornerA[127:64];
    it.b_low        = CornerB[63:0];
    it.b_high       = CornerB[127:64];
    it.lane_index   = idx;
    it.scalar_value = scal;
    it.shift_count  = cnt;
    send_item(it);
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(99) < 25) stall_left = pick_gap();
    end
  end

  // Note accepted items and check accepted results
  always @(posedge clk) begin
    pi16alu_pkg::item_t   seen;
    pi16alu_pkg::result_t got;
    if (!rst && in_valid && in_ready) begin
      seen.action       = action;
      seen.a_low        = a_low;
      seen.a_high       = a_high;
      seen.b_low        = b_low;
      seen.b_high       = b_high;
      seen.lane_index   = lane_index;
      seen.scalar_value = scalar_value;
      seen.shift_count  = shift_count;
      sb.note_item(seen);
    end
    if (!rst && out_valid && out_ready) begin
      got.result_low  = result_low;
      got.result_high = result_high;
      got.lane_value  = lane_value;
      sb.check_result(got);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every action on the corner vectors; the shift actions get counts above the cap
    for (int k = 0; k <= int'(pi16alu_pkg::ACT_SHRA); k++)
      send_corner(5'(k), 4'd7, pi16alu_pkg::SatMin, 5'(k + 7));
    send_corner(pi16alu_pkg::ACT_EXTRACT, 4'd15, pi16alu_pkg::SatMax, '0);
    send_corner(pi16alu_pkg::ACT_REPLACE, 4'd12, pi16alu_pkg::SatMax, '0);
    send_corner(pi16alu_pkg::ACT_SHRA, 4'd0, '0, pi16alu_pkg::ShiftCap);
    send_corner(pi16alu_pkg::ACT_SHL, 4'd0, '0, pi16alu_pkg::ShiftCap - 5'd1);
    send_corner(ActUnusedTop, 4'd3, pi16alu_pkg::SatMax, 5'd3);

    // Random traffic with calm stretches and one full drain midway
    for (int n = 0; n < ItemTarget; n++) begin
      calm = ((n / 150) % 4) == 2;
      if (n == ItemTarget / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      send_item(random_item());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Let the pipeline empty, then give stray results a chance to show
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered every action code, unused ones too, under random gaps and stalls.");
    $display("Items sent %0d, results checked %0d, mismatches %0d",
             sb.noted, sb.checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
